FILE: hw/rtl/sktm_pkg.sv
// Shared types and codes for the sorted key table with max tracking.
// No dependencies; used by every module of the block.
package sktm_pkg;

    // default table depth
    localparam int CAPACITY = 64;

    localparam int KEY_W    = 32;
    localparam int CHUNK_W  = 16;
    localparam int POS_W    = 6;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 7;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // request type codes
    localparam logic [REQ_W-1:0] REQ_SAVE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_READ_OOR  = 3'd6
    } status_t;

    // one table entry
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CHUNK_W-1:0] chunks;
    } entry_t;

endpackage

FILE: hw/rtl/sktm_cell.sv
// One storage cell of the entry ring: holds a single entry.
// Depends on sktm_pkg for the entry type.
module sktm_cell
(
    input  logic            clk,
    input  logic            shift_en,
    input  sktm_pkg::entry_t din,
    output sktm_pkg::entry_t q
);

    sktm_pkg::entry_t q_reg;

    // take the neighbor's entry on every walk cycle
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= din;
        end
    end

    assign q = q_reg;

endmodule

FILE: hw/rtl/sktm_ctrl.sv
// Head unit of the entry ring: walks the ring once per request, edits the
// stream of entries that re-enters the tail, tracks the maximum and holds
// the result register. Depends on sktm_pkg.
module sktm_ctrl
#(
    parameter int CAPACITY = sktm_pkg::CAPACITY
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [sktm_pkg::REQ_W-1:0]         req_type,
    input  logic [sktm_pkg::KEY_W-1:0]         page_id,
    input  logic [sktm_pkg::CHUNK_W-1:0]       free_chunks,
    input  logic [sktm_pkg::POS_W-1:0]         position,
    // ring taps
    input  sktm_pkg::entry_t                   head,
    input  sktm_pkg::entry_t                   next,
    output sktm_pkg::entry_t                   push,
    output logic                               shift_en,
    // result channel
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [sktm_pkg::STATUS_W-1:0]      status,
    output logic [sktm_pkg::SLOT_W-1:0]        slot,
    output logic [sktm_pkg::KEY_W-1:0]         entry_id,
    output logic [sktm_pkg::CHUNK_W-1:0]       entry_chunks,
    output logic [sktm_pkg::COUNT_W-1:0]       entry_count,
    output logic [sktm_pkg::CHUNK_W-1:0]       max_chunks
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int KW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > sktm_pkg::POS_W) ? CW : sktm_pkg::POS_W;
    localparam logic [KW-1:0] K_LAST = KW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_POST
    } state_t;

    state_t                            state_reg;
    logic [sktm_pkg::REQ_W-1:0]        op_reg;
    logic [sktm_pkg::KEY_W-1:0]        key_reg;
    logic [sktm_pkg::CHUNK_W-1:0]      chunks_reg;
    logic [sktm_pkg::POS_W-1:0]        pos_reg;
    logic [KW-1:0]                     k_reg;
    logic [CW-1:0]                     count_reg;
    logic                              found_reg, found_next;
    logic                              shifting_reg, shifting_next;
    sktm_pkg::entry_t                  carry_reg, carry_next;
    sktm_pkg::status_t                 status_reg, status_next;
    logic [sktm_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [sktm_pkg::KEY_W-1:0]        rid_reg, rid_next;
    logic [sktm_pkg::CHUNK_W-1:0]      rch_reg, rch_next;
    logic [sktm_pkg::CHUNK_W-1:0]      max_run_reg, max_run_next;
    logic [CW-1:0]                     count_next;

    // result register
    logic                              rsp_valid_reg;
    sktm_pkg::status_t                 rsp_status_reg;
    logic [sktm_pkg::SLOT_W-1:0]       rsp_slot_reg;
    logic [sktm_pkg::KEY_W-1:0]        rsp_id_reg;
    logic [sktm_pkg::CHUNK_W-1:0]      rsp_chunks_reg;
    logic [sktm_pkg::COUNT_W-1:0]      rsp_count_reg;
    logic [sktm_pkg::CHUNK_W-1:0]      rsp_max_reg;

    logic                              accept;
    logic                              out_free;
    logic                              rsp_load;
    logic [CW-1:0]                     k_ext;
    logic                              in_range, at_count, at_last_held, full;
    logic                              key_lt, key_eq, rm_now, push_valid;
    sktm_pkg::entry_t                  new_entry;
    sktm_pkg::status_t                 init_status;
    logic [sktm_pkg::SLOT_W-1:0]       init_slot;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_load = (state_reg == S_POST) && out_free;

    // pick the starting result for a fresh request
    always_comb
    begin
        init_status = sktm_pkg::ST_NOT_FOUND;
        init_slot   = '0;
        unique case (req_type)
            sktm_pkg::REQ_SAVE:
            begin
                init_status = sktm_pkg::ST_FULL;
                init_slot   = sktm_pkg::SLOT_W'(count_reg);
            end
            sktm_pkg::REQ_READ:
            begin
                init_status = (CMP_W'(position) < CMP_W'(count_reg)) ?
                              sktm_pkg::ST_READ_OK : sktm_pkg::ST_READ_OOR;
                init_slot   = sktm_pkg::SLOT_W'(position);
            end
            default:
            begin
                init_status = sktm_pkg::ST_NOT_FOUND;
                init_slot   = '0;
            end
        endcase
    end

    // decide what re-enters the ring tail for the entry at the head
    always_comb
    begin
        k_ext        = CW'(k_reg);
        in_range     = k_ext < count_reg;
        at_count     = k_ext == count_reg;
        at_last_held = k_ext == (count_reg - CW'(1));
        full         = count_reg == CW'(CAPACITY);
        key_lt       = head.key < key_reg;
        key_eq       = head.key == key_reg;
        new_entry    = '{key: key_reg, chunks: chunks_reg};
        rm_now       = 1'b0;

        push          = head;
        push_valid    = in_range;
        found_next    = found_reg;
        shifting_next = shifting_reg;
        carry_next    = carry_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        rid_next      = rid_reg;
        rch_next      = rch_reg;

        unique case (op_reg)
            sktm_pkg::REQ_SAVE:
            begin
                if (!found_reg)
                begin
                    priority if (in_range && key_lt)
                    begin
                        push = head;
                    end
                    else if (in_range && key_eq)
                    begin
                        push        = new_entry;
                        found_next  = 1'b1;
                        status_next = sktm_pkg::ST_REPLACED;
                        slot_next   = sktm_pkg::SLOT_W'(k_reg);
                    end
                    else if (!full)
                    begin
                        push          = new_entry;
                        push_valid    = in_range || at_count;
                        found_next    = 1'b1;
                        shifting_next = 1'b1;
                        carry_next    = head;
                        status_next   = sktm_pkg::ST_INSERTED;
                        slot_next     = sktm_pkg::SLOT_W'(k_reg);
                    end
                    else
                    begin
                        push        = head;
                        found_next  = 1'b1;
                        status_next = sktm_pkg::ST_FULL;
                        slot_next   = sktm_pkg::SLOT_W'(k_reg);
                    end
                end
                else if (shifting_reg)
                begin
                    // delay the rest of the table by one slot
                    push       = carry_reg;
                    carry_next = head;
                    push_valid = in_range || at_count;
                end
            end
            sktm_pkg::REQ_REMOVE:
            begin
                rm_now = !found_reg && in_range && key_eq;
                if (rm_now)
                begin
                    found_next  = 1'b1;
                    status_next = sktm_pkg::ST_REMOVED;
                    slot_next   = sktm_pkg::SLOT_W'(k_reg);
                end
                // pull the following entry forward over the removed one
                if (found_reg || rm_now)
                begin
                    push       = next;
                    push_valid = in_range && !at_last_held;
                end
            end
            sktm_pkg::REQ_READ:
            begin
                if ((CMP_W'(k_reg) == CMP_W'(pos_reg)) && in_range)
                begin
                    rid_next = head.key;
                    rch_next = head.chunks;
                end
            end
            default:
            begin
                push = head;
            end
        endcase

        max_run_next = (push_valid && (push.chunks > max_run_reg)) ?
                       push.chunks : max_run_reg;
    end

    // count after the request
    always_comb
    begin
        priority if (status_reg == sktm_pkg::ST_INSERTED)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (status_reg == sktm_pkg::ST_REMOVED)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // sequence the walk and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            op_reg         <= '0;
            key_reg        <= '0;
            chunks_reg     <= '0;
            pos_reg        <= '0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            shifting_reg   <= 1'b0;
            carry_reg      <= '0;
            status_reg     <= sktm_pkg::ST_NOT_FOUND;
            slot_reg       <= '0;
            rid_reg        <= '0;
            rch_reg        <= '0;
            max_run_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= sktm_pkg::ST_NOT_FOUND;
            rsp_slot_reg   <= '0;
            rsp_id_reg     <= '0;
            rsp_chunks_reg <= '0;
            rsp_count_reg  <= '0;
            rsp_max_reg    <= '0;
        end
        else
        begin
            // drop a result once taken, unless a new one loads now
            if (rsp_valid_reg && !rsp_stall && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= req_type;
                        key_reg      <= page_id;
                        chunks_reg   <= free_chunks;
                        pos_reg      <= position;
                        k_reg        <= '0;
                        found_reg    <= 1'b0;
                        shifting_reg <= 1'b0;
                        status_reg   <= init_status;
                        slot_reg     <= init_slot;
                        rid_reg      <= '0;
                        rch_reg      <= '0;
                        max_run_reg  <= '0;
                        state_reg    <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    found_reg    <= found_next;
                    shifting_reg <= shifting_next;
                    carry_reg    <= carry_next;
                    status_reg   <= status_next;
                    slot_reg     <= slot_next;
                    rid_reg      <= rid_next;
                    rch_reg      <= rch_next;
                    max_run_reg  <= max_run_next;
                    k_reg        <= k_reg + KW'(1);
                    if (k_reg == K_LAST)
                    begin
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    if (out_free)
                    begin
                        count_reg      <= count_next;
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_slot_reg   <= slot_reg;
                        rsp_id_reg     <= rid_reg;
                        rsp_chunks_reg <= rch_reg;
                        rsp_count_reg  <= sktm_pkg::COUNT_W'(count_next);
                        rsp_max_reg    <= max_run_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall    = state_reg != S_IDLE;
    assign shift_en     = state_reg == S_WALK;
    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign slot         = rsp_slot_reg;
    assign entry_id     = rsp_id_reg;
    assign entry_chunks = rsp_chunks_reg;
    assign entry_count  = rsp_count_reg;
    assign max_chunks   = rsp_max_reg;

endmodule

FILE: hw/rtl/sorted_key_table_with_max_tracking_unit.sv
// Top level of the sorted key table: a ring of entry cells and its head unit.
// Depends on sktm_pkg, sktm_cell and sktm_ctrl.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid/req_stall  | req_type page_id free_chunks position
//   rsp     | out       | rsp_valid/rsp_stall  | status slot entry_id entry_chunks
//           |           |                      | entry_count max_chunks
//
// For every request the head unit sees one entry per cycle as the whole ring rotates
// once past it; then the S_POST state commits the count and loads the result register.
// One request is in work at a time; req_stall is high from acceptance until the
// result is loaded. A waiting result does not block the next request.
// A stalled result holds the walk's end until the result register frees up.
// Reset clears the entry count; the cells are not cleared and need no clearing pass.
module sorted_key_table_with_max_tracking_unit
#(
    parameter int CAPACITY = sktm_pkg::CAPACITY
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [sktm_pkg::REQ_W-1:0]     req_type,
    input  logic [sktm_pkg::KEY_W-1:0]     page_id,
    input  logic [sktm_pkg::CHUNK_W-1:0]   free_chunks,
    input  logic [sktm_pkg::POS_W-1:0]     position,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [sktm_pkg::STATUS_W-1:0]  status,
    output logic [sktm_pkg::SLOT_W-1:0]    slot,
    output logic [sktm_pkg::KEY_W-1:0]     entry_id,
    output logic [sktm_pkg::CHUNK_W-1:0]   entry_chunks,
    output logic [sktm_pkg::COUNT_W-1:0]   entry_count,
    output logic [sktm_pkg::CHUNK_W-1:0]   max_chunks
);

    sktm_pkg::entry_t ring_q [CAPACITY];
    sktm_pkg::entry_t push;
    logic             shift_en;

    // build the ring: each cell takes from its upper neighbor, the top from the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_top
            sktm_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (push),
                .q        (ring_q[i])
            );
        end
        else
        begin : g_mid
            sktm_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (ring_q[i+1]),
                .q        (ring_q[i])
            );
        end
    end

    sktm_ctrl
    #(
        .CAPACITY (CAPACITY)
    )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .page_id      (page_id),
        .free_chunks  (free_chunks),
        .position     (position),
        .head         (ring_q[0]),
        .next         (ring_q[1]),
        .push         (push),
        .shift_en     (shift_en),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .slot         (slot),
        .entry_id     (entry_id),
        .entry_chunks (entry_chunks),
        .entry_count  (entry_count),
        .max_chunks   (max_chunks)
    );

endmodule

FILE: hw/rtl/sktm_checker.sv
// Port-level checks for the sorted key table, attached by bind to the top level.
// Depends on sktm_pkg for field widths and status codes.
module sktm_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [sktm_pkg::STATUS_W-1:0]  status,
    input  logic [sktm_pkg::SLOT_W-1:0]    slot,
    input  logic [sktm_pkg::KEY_W-1:0]     entry_id,
    input  logic [sktm_pkg::CHUNK_W-1:0]   entry_chunks,
    input  logic [sktm_pkg::COUNT_W-1:0]   entry_count,
    input  logic [sktm_pkg::CHUNK_W-1:0]   max_chunks
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot) &&
        $stable(entry_id) && $stable(entry_chunks) && $stable(entry_count) &&
        $stable(max_chunks))
        else $error("result changed while stalled");

    // report entry fields only for a successful read
    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != sktm_pkg::ST_READ_OK) |->
        (entry_id == '0) && (entry_chunks == '0))
        else $error("entry fields set on a non-read result");

    // stall the request side right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side not stalled during a walk");

endmodule

bind sorted_key_table_with_max_tracking_unit sktm_checker u_sktm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .slot         (slot),
    .entry_id     (entry_id),
    .entry_chunks (entry_chunks),
    .entry_count  (entry_count),
    .max_chunks   (max_chunks)
);
